@@ hdl/pol_pkg.sv @@
// Shared types and constants for the positional ordered list.
`default_nettype none

package pol_pkg;

  // List geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 8;

  // Fixed field widths of the request and response words.
  localparam int FUNC_W  = 3;
  localparam int VAL_W   = 8;
  localparam int POS_W   = 5;
  localparam int STS_W   = 2;
  localparam int CNTO_W  = 5;
  localparam int ELEM_W  = 8;

  // Derived internal widths.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Request function codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_AT    = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_BACK  = 3'd4,
    FN_DEL_AT    = 3'd5,
    FN_DISPLAY   = 3'd6,
    FN_COUNT     = 3'd7
  } func_e;

  // Response status codes.
  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_BAD_POS = 2'd1,
    STS_FULL    = 2'd2,
    STS_EMPTY   = 2'd3
  } status_e;

  // Operation applied to every cell of the chain at once.
  typedef enum logic [1:0] {
    CO_HOLD = 2'd0,
    CO_INS  = 2'd1,
    CO_DEL  = 2'd2,
    CO_ROT  = 2'd3
  } cell_op_e;

  // Sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DISP = 1'b1
  } state_e;

  // Request word.
  typedef struct packed {
    func_e              func;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   position;
  } in_word_t;

  // Response word.
  typedef struct packed {
    status_e            status;
    logic [CNTO_W-1:0]  count;
    logic [ELEM_W-1:0]  element;
    logic               element_valid;
    logic               last;
  } out_word_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_e               op;
    logic [IDX_W-1:0]       tgt;
    logic [IDX_W-1:0]       last;
    logic [DATA_WIDTH-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/positional_ordered_list.sv @@
// Top level of the positional ordered list: request sequencer and cell chain.
//
//   Channel  Direction  Handshake                Word
//   in       input      in_valid_i / in_stall_o  in_word_t  (func, value, position)
//   out      output     out_valid_o / out_stall_i out_word_t (status, count, element,
//                                                 element_valid, last)
//
// An accepted insert or delete shifts the whole chain at once; for an insert, delete
// or count request the single response word is registered the next cycle.
// A display of N elements takes the request and then one rotation step of the chain
// per word, each step waiting for a free output slot.
// Reset clears the occupancy, the sequencer and the output valid; cell contents
// are undefined until written. A stalled output holds its word and the sequencer.
`default_nettype none

module positional_ordered_list
  import pol_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      occ_q, occ_d;
  logic [IDX_W-1:0]      disp_q, disp_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_data_q, out_data_d;

  cell_ctrl_t            ctrl;
  logic                  out_free;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [IDX_W-1:0]      last_idx;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      occ_x;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  // Handshake: a request is taken only when idle and the output slot frees up.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign full     = (occ_q == CNT_W'(DEPTH));
  assign empty    = (occ_q == '0);
  assign last_idx = IDX_W'(occ_q - CNT_W'(1));
  assign pos_x    = CMP_W'(in_data_i.position);
  assign occ_x    = CMP_W'(occ_q);

  // Next state, chain control and response word.
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    disp_d      = disp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    ctrl.op    = CO_HOLD;
    ctrl.tgt   = '0;
    ctrl.last  = last_idx;
    ctrl.value = DATA_WIDTH'(in_data_i.value);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_data_d.status        = STS_OK;
          out_data_d.element       = '0;
          out_data_d.element_valid = 1'b0;
          out_data_d.last          = 1'b1;
          out_valid_d              = 1'b1;

          unique case (in_data_i.func)
            FN_INS_FRONT: begin
              if (full) begin
                out_data_d.status = STS_FULL;
              end else begin
                ctrl.op  = CO_INS;
                ctrl.tgt = '0;
                occ_d    = occ_q + CNT_W'(1);
              end
            end
            FN_INS_BACK: begin
              if (full) begin
                out_data_d.status = STS_FULL;
              end else begin
                ctrl.op  = CO_INS;
                ctrl.tgt = IDX_W'(occ_q);
                occ_d    = occ_q + CNT_W'(1);
              end
            end
            FN_INS_AT: begin
              // Position check comes before the full check.
              if (pos_x == '0 || pos_x > occ_x + CMP_W'(1)) begin
                out_data_d.status = STS_BAD_POS;
              end else if (full) begin
                out_data_d.status = STS_FULL;
              end else begin
                ctrl.op  = CO_INS;
                ctrl.tgt = IDX_W'(pos_x - CMP_W'(1));
                occ_d    = occ_q + CNT_W'(1);
              end
            end
            FN_DEL_FRONT: begin
              if (empty) begin
                out_data_d.status = STS_EMPTY;
              end else begin
                ctrl.op  = CO_DEL;
                ctrl.tgt = '0;
                occ_d    = occ_q - CNT_W'(1);
              end
            end
            FN_DEL_BACK: begin
              if (empty) begin
                out_data_d.status = STS_EMPTY;
              end else begin
                ctrl.op  = CO_DEL;
                ctrl.tgt = last_idx;
                occ_d    = occ_q - CNT_W'(1);
              end
            end
            FN_DEL_AT: begin
              if (pos_x == '0 || pos_x > occ_x) begin
                out_data_d.status = STS_BAD_POS;
              end else begin
                ctrl.op  = CO_DEL;
                ctrl.tgt = IDX_W'(pos_x - CMP_W'(1));
                occ_d    = occ_q - CNT_W'(1);
              end
            end
            FN_DISPLAY: begin
              // A non-empty list streams from the display state instead.
              if (!empty) begin
                out_valid_d = 1'b0;
                state_d     = S_DISP;
                disp_d      = '0;
              end
            end
            FN_COUNT: begin
              out_data_d.status = STS_OK;
            end
            default: begin
              out_data_d.status = STS_OK;
            end
          endcase
          out_data_d.count = CNTO_W'(occ_d);
        end
      end
      S_DISP: begin
        // One word per free output slot, front cell first, then rotate.
        if (out_free) begin
          ctrl.op                  = CO_ROT;
          out_valid_d              = 1'b1;
          out_data_d.status        = STS_OK;
          out_data_d.count         = CNTO_W'(occ_q);
          out_data_d.element       = ELEM_W'(cell_data[0]);
          out_data_d.element_valid = 1'b1;
          out_data_d.last          = (disp_q == last_idx);
          disp_d                   = disp_q + IDX_W'(1);
          if (disp_q == last_idx) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      disp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      disp_q      <= disp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Response word register.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Cell chain: cell 0 is the front of the list.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (g == 0) begin : g_front
      assign left_w = cell_data[g];
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_back
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    pol_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (IDX_W'(g)),
      .left_i     (left_w),
      .right_i    (right_w),
      .wrap_i     (cell_data[0]),
      .data_o     (cell_data[g])
    );
  end

endmodule

`default_nettype wire

@@ hdl/pol_cell.sv @@
// One storage cell of the list chain with its shift and load selection.
`default_nettype none

module pol_cell
  import pol_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic [IDX_W-1:0]       cell_idx_i,
  input  wire logic [DATA_WIDTH-1:0]  left_i,
  input  wire logic [DATA_WIDTH-1:0]  right_i,
  input  wire logic [DATA_WIDTH-1:0]  wrap_i,
  output logic      [DATA_WIDTH-1:0]  data_o
);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  // Pick the new content from the value, a neighbor or the front cell.
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      CO_INS: begin
        // Cells behind the insert point move one place toward the back.
        if (cell_idx_i == ctrl_i.tgt) begin
          data_d = ctrl_i.value;
        end else if (cell_idx_i > ctrl_i.tgt) begin
          data_d = left_i;
        end
      end
      CO_DEL: begin
        // Cells from the delete point on move one place toward the front.
        if (cell_idx_i >= ctrl_i.tgt) begin
          data_d = right_i;
        end
      end
      CO_ROT: begin
        // Readout rotates the occupied cells; the front wraps to the back.
        if (cell_idx_i < ctrl_i.last) begin
          data_d = right_i;
        end else if (cell_idx_i == ctrl_i.last) begin
          data_d = wrap_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  // Payload register, no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire
